[src/rv32eu_pkg.sv]
// ----------------------------------------------------------------------------
// rv32eu_pkg: shared definitions for the RV32I execute unit
// Command codes, memory geometry, channel payload types and the internal
// request and result bundles that pass between the unit's modules.
// ----------------------------------------------------------------------------
package rv32eu_pkg;

    // Data memory geometry. The memory is split into four byte-wide banks.
    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned MEM_ROWS  = MEM_BYTES / 4;
    localparam int unsigned ROW_W     = $clog2(MEM_ROWS);
    localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

    // Architectural constants.
    localparam logic [4:0]  SP_INDEX   = 5'd2;
    localparam logic [4:0]  A0_INDEX   = 5'd10;
    localparam logic [31:0] SP_RESET   = 32'(MEM_BYTES);
    localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;

    // Pre-decoded command codes.
    localparam logic [5:0] CMD_LUI   = 6'd0;
    localparam logic [5:0] CMD_AUIPC = 6'd1;
    localparam logic [5:0] CMD_ADD   = 6'd2;
    localparam logic [5:0] CMD_SUB   = 6'd3;
    localparam logic [5:0] CMD_SLL   = 6'd4;
    localparam logic [5:0] CMD_SLT   = 6'd5;
    localparam logic [5:0] CMD_SLTU  = 6'd6;
    localparam logic [5:0] CMD_XOR   = 6'd7;
    localparam logic [5:0] CMD_SRL   = 6'd8;
    localparam logic [5:0] CMD_SRA   = 6'd9;
    localparam logic [5:0] CMD_OR    = 6'd10;
    localparam logic [5:0] CMD_AND   = 6'd11;
    localparam logic [5:0] CMD_ADDI  = 6'd12;
    localparam logic [5:0] CMD_SLTI  = 6'd13;
    localparam logic [5:0] CMD_SLTIU = 6'd14;
    localparam logic [5:0] CMD_XORI  = 6'd15;
    localparam logic [5:0] CMD_ORI   = 6'd16;
    localparam logic [5:0] CMD_ANDI  = 6'd17;
    localparam logic [5:0] CMD_SLLI  = 6'd18;
    localparam logic [5:0] CMD_SRLI  = 6'd19;
    localparam logic [5:0] CMD_SRAI  = 6'd20;
    localparam logic [5:0] CMD_LB    = 6'd21;
    localparam logic [5:0] CMD_LH    = 6'd22;
    localparam logic [5:0] CMD_LW    = 6'd23;
    localparam logic [5:0] CMD_LBU   = 6'd24;
    localparam logic [5:0] CMD_LHU   = 6'd25;
    localparam logic [5:0] CMD_SB    = 6'd26;
    localparam logic [5:0] CMD_SH    = 6'd27;
    localparam logic [5:0] CMD_SW    = 6'd28;
    localparam logic [5:0] CMD_JAL   = 6'd29;
    localparam logic [5:0] CMD_JALR  = 6'd30;
    localparam logic [5:0] CMD_BEQ   = 6'd31;
    localparam logic [5:0] CMD_BNE   = 6'd32;
    localparam logic [5:0] CMD_BLT   = 6'd33;
    localparam logic [5:0] CMD_BGE   = 6'd34;
    localparam logic [5:0] CMD_BLTU  = 6'd35;
    localparam logic [5:0] CMD_BGEU  = 6'd36;

    // Input item.
    typedef struct packed {
        logic [5:0]         cmd;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic signed [31:0] immediate;
    } req_t;

    // Result item.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  written_index;
        logic [31:0] written_value;
        logic        mem_fault;
        logic [15:0] return_code;
    } rsp_t;

    // One access to the four data memory banks.
    typedef struct packed {
        logic                       rd_en;
        logic [3:0]                 wr_en;
        logic [3:0][ROW_W-1:0]      row;
        logic [3:0][7:0]            wdata;
    } dmem_req_t;

    // Outcome of the execute stage.
    typedef struct packed {
        logic        wr;
        logic [31:0] val;
        logic [31:0] npc;
        logic        is_load;
        logic        is_store;
        logic        fault;
        logic [31:0] addr;
        logic [2:0]  size;
    } ex_res_t;

endpackage

[src/rv32eu_regfile.sv]
// ----------------------------------------------------------------------------
// rv32eu_regfile: 32 x 32 register file
// Synchronous memory with two registered read ports, one write port, a
// write-to-read bypass and per-entry valid bits that supply reset values.
// ----------------------------------------------------------------------------
module rv32eu_regfile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_en,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata
);

    logic [31:0] rf_mem [32];
    logic [31:0] valid_reg;
    logic [31:0] rdata_a_reg;
    logic [31:0] rdata_b_reg;

    // Entries never written since reset read as their reset value.
    function automatic logic [31:0] reset_value(input logic [4:0] idx);
        reset_value = (idx == rv32eu_pkg::SP_INDEX) ? rv32eu_pkg::SP_RESET : '0;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (we && (waddr == raddr_a))
            begin
                rdata_a_reg <= wdata;
            end
            else if (valid_reg[raddr_a])
            begin
                rdata_a_reg <= rf_mem[raddr_a];
            end
            else
            begin
                rdata_a_reg <= reset_value(raddr_a);
            end

            if (we && (waddr == raddr_b))
            begin
                rdata_b_reg <= wdata;
            end
            else if (valid_reg[raddr_b])
            begin
                rdata_b_reg <= rf_mem[raddr_b];
            end
            else
            begin
                rdata_b_reg <= reset_value(raddr_b);
            end
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[src/rv32eu_dmem.sv]
// ----------------------------------------------------------------------------
// rv32eu_dmem: byte-banked data memory
// Four byte-wide synchronous banks, each with its own row address, so an
// unaligned access of up to four bytes needs only a single access. A clearing
// pass after reset zeroes one row per cycle.
// ----------------------------------------------------------------------------
module rv32eu_dmem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rv32eu_pkg::dmem_req_t req,
    output logic [3:0][7:0]       rdata,
    output logic                  busy
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [rv32eu_pkg::ROW_W-1:0] clear_row_reg;
    logic [rv32eu_pkg::ROW_W-1:0] clear_row_next;

    always_comb
    begin
        busy_next      = busy_reg;
        clear_row_next = clear_row_reg;
        if (busy_reg)
        begin
            if (clear_row_reg == rv32eu_pkg::ROW_W'(rv32eu_pkg::MEM_ROWS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clear_row_next = clear_row_reg + rv32eu_pkg::ROW_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            clear_row_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            clear_row_reg <= clear_row_next;
        end
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_bank
        logic [7:0] bank_mem [rv32eu_pkg::MEM_ROWS];
        logic [7:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (busy_reg)
            begin
                bank_mem[clear_row_reg] <= '0;
            end
            else if (req.wr_en[j])
            begin
                bank_mem[req.row[j]] <= req.wdata[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (req.rd_en)
            begin
                q_reg <= bank_mem[req.row[j]];
            end
        end

        assign rdata[j] = q_reg;
    end

    assign busy = busy_reg;

endmodule

[src/rv32eu_exec.sv]
// ----------------------------------------------------------------------------
// rv32eu_exec: execute stage datapath
// Computes the ALU result, upper immediates, link values, the effective
// address with its range check, branch decisions and the next PC.
// ----------------------------------------------------------------------------
module rv32eu_exec (
    input  logic [5:0]          cmd,
    input  logic [31:0]         imm,
    input  logic [31:0]         pc,
    input  logic [31:0]         a,
    input  logic [31:0]         b,
    output rv32eu_pkg::ex_res_t res
);

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_SLL,
        ALU_SLT,
        ALU_SLTU,
        ALU_XOR,
        ALU_SRL,
        ALU_SRA,
        ALU_OR,
        ALU_AND
    } alu_op_t;

    // Register and immediate forms share one ALU operation.
    function automatic alu_op_t op_of(input logic [5:0] c);
        case (c)
            rv32eu_pkg::CMD_SUB:   op_of = ALU_SUB;
            rv32eu_pkg::CMD_SLL,
            rv32eu_pkg::CMD_SLLI:  op_of = ALU_SLL;
            rv32eu_pkg::CMD_SLT,
            rv32eu_pkg::CMD_SLTI:  op_of = ALU_SLT;
            rv32eu_pkg::CMD_SLTU,
            rv32eu_pkg::CMD_SLTIU: op_of = ALU_SLTU;
            rv32eu_pkg::CMD_XOR,
            rv32eu_pkg::CMD_XORI:  op_of = ALU_XOR;
            rv32eu_pkg::CMD_SRL,
            rv32eu_pkg::CMD_SRLI:  op_of = ALU_SRL;
            rv32eu_pkg::CMD_SRA,
            rv32eu_pkg::CMD_SRAI:  op_of = ALU_SRA;
            rv32eu_pkg::CMD_OR,
            rv32eu_pkg::CMD_ORI:   op_of = ALU_OR;
            rv32eu_pkg::CMD_AND,
            rv32eu_pkg::CMD_ANDI:  op_of = ALU_AND;
            default:               op_of = ALU_ADD;
        endcase
    endfunction

    logic [31:0] pc_plus4;
    logic [31:0] upper;
    logic [31:0] addr;
    logic [31:0] alu_b;
    logic [31:0] alu_y;
    logic [4:0]  shamt;
    logic [32:0] end_addr;
    logic        eq;
    logic        lt_s;
    logic        lt_u;
    logic        take;
    logic        is_mem;

    always_comb
    begin
        pc_plus4 = pc + 32'd4;
        upper    = imm & rv32eu_pkg::UPPER_MASK;
        addr     = a + imm;
        alu_b    = (cmd inside {[rv32eu_pkg::CMD_ADD:rv32eu_pkg::CMD_AND]}) ? b : imm;
        shamt    = alu_b[4:0];
        eq       = (a == b);
        lt_s     = ($signed(a) < $signed(b));
        lt_u     = (a < b);

        case (op_of(cmd))
            ALU_ADD:  alu_y = a + alu_b;
            ALU_SUB:  alu_y = a - alu_b;
            ALU_SLL:  alu_y = a << shamt;
            ALU_SLT:  alu_y = {31'b0, $signed(a) < $signed(alu_b)};
            ALU_SLTU: alu_y = {31'b0, a < alu_b};
            ALU_XOR:  alu_y = a ^ alu_b;
            ALU_SRL:  alu_y = a >> shamt;
            ALU_SRA:  alu_y = $unsigned($signed(a) >>> shamt);
            ALU_OR:   alu_y = a | alu_b;
            ALU_AND:  alu_y = a & alu_b;
            default:  alu_y = a + alu_b;
        endcase

        case (cmd)
            rv32eu_pkg::CMD_BEQ:  take = eq;
            rv32eu_pkg::CMD_BNE:  take = !eq;
            rv32eu_pkg::CMD_BLT:  take = lt_s;
            rv32eu_pkg::CMD_BGE:  take = !lt_s;
            rv32eu_pkg::CMD_BLTU: take = lt_u;
            rv32eu_pkg::CMD_BGEU: take = !lt_u;
            default:              take = 1'b0;
        endcase

        res          = '0;
        res.npc      = pc_plus4;
        res.addr     = addr;
        res.is_load  = cmd inside {[rv32eu_pkg::CMD_LB:rv32eu_pkg::CMD_LHU]};
        res.is_store = cmd inside {[rv32eu_pkg::CMD_SB:rv32eu_pkg::CMD_SW]};
        is_mem       = res.is_load || res.is_store;

        if (cmd inside {rv32eu_pkg::CMD_LB, rv32eu_pkg::CMD_LBU, rv32eu_pkg::CMD_SB})
        begin
            res.size = 3'd1;
        end
        else if (cmd inside {rv32eu_pkg::CMD_LH, rv32eu_pkg::CMD_LHU, rv32eu_pkg::CMD_SH})
        begin
            res.size = 3'd2;
        end
        else
        begin
            res.size = 3'd4;
        end

        end_addr  = {1'b0, addr} + {30'b0, res.size};
        res.fault = is_mem && (end_addr > rv32eu_pkg::MEM_LIMIT);

        if (cmd == rv32eu_pkg::CMD_LUI)
        begin
            res.wr  = 1'b1;
            res.val = upper;
        end
        else if (cmd == rv32eu_pkg::CMD_AUIPC)
        begin
            res.wr  = 1'b1;
            res.val = pc + upper;
        end
        else if (cmd inside {[rv32eu_pkg::CMD_ADD:rv32eu_pkg::CMD_SRAI]})
        begin
            res.wr  = 1'b1;
            res.val = alu_y;
        end
        else if (res.is_load)
        begin
            // The loaded value itself arrives from memory one stage later.
            res.wr = !res.fault;
        end
        else if (cmd == rv32eu_pkg::CMD_JAL)
        begin
            res.wr  = 1'b1;
            res.val = pc_plus4;
            res.npc = pc + {imm[30:0], 1'b0};
        end
        else if (cmd == rv32eu_pkg::CMD_JALR)
        begin
            res.wr  = 1'b1;
            res.val = pc_plus4;
            res.npc = {addr[31:1], 1'b0};
        end
        else if (take)
        begin
            res.npc = pc + imm;
        end
    end

endmodule

[src/rv32eu_core.sv]
// ----------------------------------------------------------------------------
// rv32i_execute_unit_core: RV32I execute unit top level
// Executes one pre-decoded instruction per transfer against the register
// file, program counter and byte-banked data memory, and returns one result.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake               | Payload
//  --------+-----+-------------------------+-----------------------------------
//  req     | in  | req_valid / req_ready   | rv32eu_pkg::req_t, one instruction
//  rsp     | out | rsp_valid / rsp_ready   | rv32eu_pkg::rsp_t, one result
//  cfg     | in  | cfg_wr_en (no wait)     | cfg_wr_data, start PC
//
//  Sustained rate is one instruction per cycle while rsp_ready is high; a request
//  passes the register file read, execute with the data memory access and the
//  result stage holding the memory read data before its result is valid.
//  After reset the data memory is zeroed one four-byte row per cycle, over
//  MEM_BYTES / 4 rows (16384 at 64 KiB) while req_ready stays low. With a result held
//  and rsp_ready low both stages hold; an empty execute stage still takes a request.
//
module rv32i_execute_unit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  rv32eu_pkg::req_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rv32eu_pkg::rsp_t  rsp,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data
);

    // Handshake and pipeline movement.
    logic adv;
    logic req_fire;
    logic rsp_fire;
    logic s1_go;
    logic clear_busy;

    // Execute stage.
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [5:0]  s1_cmd_reg;
    logic [4:0]  s1_rd_reg;
    logic [4:0]  s1_rs1_reg;
    logic [4:0]  s1_rb_reg;
    logic [31:0] s1_imm_reg;

    // Result stage.
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic [31:0] s2_npc_reg;
    logic        s2_wr_reg;
    logic [4:0]  s2_rd_reg;
    logic [31:0] s2_val_reg;
    logic        s2_load_reg;
    logic [5:0]  s2_cmd_reg;
    logic [1:0]  s2_off_reg;
    logic        s2_fault_reg;

    // Architectural state held in flops.
    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic [15:0] a0_reg;
    logic [15:0] a0_next;

    logic                  req_is_store;
    logic [4:0]            rb_idx;
    logic [31:0]           rf_a;
    logic [31:0]           rf_b;
    logic [31:0]           a_op;
    logic [31:0]           b_op;
    logic [31:0]           wb_value;
    logic [31:0]           ld_word;
    logic [31:0]           ld_value;
    logic                  store_go;
    logic                  load_go;
    logic [1:0]            off;
    logic [1:0]            lane;
    logic [rv32eu_pkg::ROW_W-1:0] base_row;
    rv32eu_pkg::ex_res_t   ex;
    rv32eu_pkg::dmem_req_t dmem_req;
    logic [3:0][7:0]       dmem_q;

    // Both stages move together whenever the result stage can be emptied.
    assign adv       = !s2_valid_reg || rsp_ready;
    assign req_ready = !clear_busy && (adv || !s1_valid_reg);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = s2_valid_reg;
    assign rsp_fire  = rsp_valid && rsp_ready;
    assign s1_go     = s1_valid_reg && adv;

    // Stores read their data register through the second read port.
    assign req_is_store = req.cmd inside {[rv32eu_pkg::CMD_SB:rv32eu_pkg::CMD_SW]};
    assign rb_idx       = req_is_store ? req.dest_reg : req.src2_reg;

    // The register file is written when a result leaves; an instruction read
    // in the same cycle picks the value up through the register file bypass.
    rv32eu_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (req_fire),
        .raddr_a (req.src1_reg),
        .raddr_b (rb_idx),
        .rdata_a (rf_a),
        .rdata_b (rf_b),
        .we      (rsp_fire && s2_wr_reg),
        .waddr   (s2_rd_reg),
        .wdata   (wb_value)
    );

    // The result stage always holds the immediate predecessor of the execute
    // stage and has not yet written its register, so forward from it.
    always_comb
    begin
        if (s2_valid_reg && s2_wr_reg && (s2_rd_reg == s1_rs1_reg))
        begin
            a_op = wb_value;
        end
        else
        begin
            a_op = rf_a;
        end

        if (s2_valid_reg && s2_wr_reg && (s2_rd_reg == s1_rb_reg))
        begin
            b_op = wb_value;
        end
        else
        begin
            b_op = rf_b;
        end
    end

    rv32eu_exec u_exec (
        .cmd (s1_cmd_reg),
        .imm (s1_imm_reg),
        .pc  (pc_reg),
        .a   (a_op),
        .b   (b_op),
        .res (ex)
    );

    // Memory access. Each bank takes the byte that falls into it, at the base
    // row or at the next row when the access wraps past the end of a row.
    // Only one instruction touches memory per cycle, from the execute stage,
    // so loads and stores never overlap on an entry.
    assign store_go = s1_go && ex.is_store && !ex.fault;
    assign load_go  = s1_go && ex.is_load && !ex.fault;
    assign off      = ex.addr[1:0];
    assign base_row = ex.addr[rv32eu_pkg::ROW_W+1:2];

    always_comb
    begin
        dmem_req       = '0;
        dmem_req.rd_en = load_go;
        lane           = '0;
        for (int j = 0; j < 4; j++)
        begin
            lane                 = 2'(j) - off;
            dmem_req.row[j]      = base_row
                                 + rv32eu_pkg::ROW_W'((3'(j) < {1'b0, off}) ? 1 : 0);
            dmem_req.wr_en[j]    = store_go && ({1'b0, lane} < ex.size);
            dmem_req.wdata[j]    = b_op[{lane, 3'b000} +: 8];
        end
    end

    rv32eu_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dmem_req),
        .rdata (dmem_q),
        .busy  (clear_busy)
    );

    // Reassemble the loaded bytes in address order and extend them.
    always_comb
    begin
        ld_word = {dmem_q[s2_off_reg + 2'd3], dmem_q[s2_off_reg + 2'd2],
                   dmem_q[s2_off_reg + 2'd1], dmem_q[s2_off_reg]};
        case (s2_cmd_reg)
            rv32eu_pkg::CMD_LB:  ld_value = {{24{ld_word[7]}}, ld_word[7:0]};
            rv32eu_pkg::CMD_LH:  ld_value = {{16{ld_word[15]}}, ld_word[15:0]};
            rv32eu_pkg::CMD_LBU: ld_value = {24'b0, ld_word[7:0]};
            rv32eu_pkg::CMD_LHU: ld_value = {16'b0, ld_word[15:0]};
            default:             ld_value = ld_word;
        endcase
        wb_value = s2_load_reg ? ld_value : s2_val_reg;
    end

    // The result item. a0 is tracked in a 16-bit shadow so that the return
    // code can be shown without a third register file read port.
    always_comb
    begin
        rsp.next_pc       = s2_npc_reg;
        rsp.reg_written   = s2_wr_reg;
        rsp.written_index = s2_wr_reg ? s2_rd_reg : '0;
        rsp.written_value = s2_wr_reg ? wb_value : '0;
        rsp.mem_fault     = s2_fault_reg;
        rsp.return_code   = (s2_wr_reg && (s2_rd_reg == rv32eu_pkg::A0_INDEX))
                          ? wb_value[15:0] : a0_reg;
    end

    // Control state.
    always_comb
    begin
        s1_valid_next = req_fire || (s1_valid_reg && !adv);
        s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;

        // A start PC write loads the program counter directly; the user must see that it
        // only happens while the unit is idle, as the block does not enforce this.
        if (cfg_wr_en)
        begin
            pc_next = cfg_wr_data;
        end
        else if (s1_go)
        begin
            pc_next = ex.npc;
        end
        else
        begin
            pc_next = pc_reg;
        end

        if (rsp_fire && s2_wr_reg && (s2_rd_reg == rv32eu_pkg::A0_INDEX))
        begin
            a0_next = wb_value[15:0];
        end
        else
        begin
            a0_next = a0_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= '0;
            a0_reg       <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            pc_reg       <= pc_next;
            a0_reg       <= a0_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_cmd_reg <= req.cmd;
            s1_rd_reg  <= req.dest_reg;
            s1_rs1_reg <= req.src1_reg;
            s1_rb_reg  <= rb_idx;
            s1_imm_reg <= $unsigned(req.immediate);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            s2_npc_reg   <= ex.npc;
            s2_wr_reg    <= ex.wr && (s1_rd_reg != '0);
            s2_rd_reg    <= s1_rd_reg;
            s2_val_reg   <= ex.val;
            s2_load_reg  <= ex.is_load;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_off_reg   <= off;
            s2_fault_reg <= ex.fault;
        end
    end

`ifndef ASSERT_OFF
    // An instruction in execute with an empty result stage must move on.
    a_exec_drains: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_valid_reg |=> s2_valid_reg)
        else $error("execute stage did not advance into an empty result stage");

    // The program counter after a step matches the result that step reports.
    a_pc_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && !cfg_wr_en |=> pc_reg == s2_npc_reg)
        else $error("program counter differs from reported next PC");

    // A faulting access leaves registers alone.
    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mem_fault |-> !rsp.reg_written)
        else $error("register written by a faulting memory access");

    // x0 is never reported as written.
    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.reg_written |-> rsp.written_index != '0)
        else $error("write to x0 reported");

    // No instruction reaches memory while the clearing pass runs.
    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> !dmem_req.rd_en && (dmem_req.wr_en == '0))
        else $error("data memory accessed during clearing pass");
`endif

endmodule
